// File: rtl/caldate_pkg.sv
// caldate_pkg: shared types, codes and calendar helpers for the date counter.
// No dependencies; caldate_ctrl, caldate_dp and calendar_date_counter_top import it.
`timescale 1ns / 1ps
`default_nettype none

package caldate_pkg;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam logic [3:0]  MONTH_LAST = 4'd12;
	localparam logic [11:0] YEAR_MIN   = 12'd1900;
	localparam logic [11:0] YEAR_MAX   = 12'd2100;
	localparam logic [11:0] YEAR_TOP   = 12'd4095;
	localparam logic [4:0]  FEB_LEAP   = 5'd29;

	// 25 * 3113 == 1 (mod 4096): y is a multiple of 25 exactly when
	// y * 3113 mod 4096 <= 4095 / 25
	localparam logic [11:0] INV25     = 12'd3113;
	localparam logic [11:0] DIV25_LIM = 12'd163;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MONTH = 3'd1,
		ST_BAD_YEAR  = 3'd2,
		ST_BAD_DAY   = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef struct packed {
		logic        command;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
		logic [11:0] load_year;
		logic [15:0] advance_days;
	} item_t;

	typedef struct packed {
		logic [3:0]  cur_month;
		logic [4:0]  cur_day;
		logic [11:0] cur_year;
		status_t     status;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // check and apply a load transaction
		logic adv_start; // latch day count, clear status
		logic step;      // one day forward, count down
		logic ovf;       // flag year overflow
		logic out_wr;    // capture date and status into output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;
		logic at_top;
		logic out_free;
	} dp_sts_t;

	function automatic logic is_leap(input logic [11:0] y);
		logic [11:0] p;
		logic        div25;
		p     = 12'(y * INV25);
		div25 = (p <= DIV25_LIM);
		// div by 4, and either not div by 25 (so not by 100) or div by 16 (so by 400)
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic [11:0] y);
		logic [4:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                       d = is_leap(y) ? FEB_LEAP : 5'd28;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// File: rtl/caldate_in_if.sv
// caldate_in_if: valid/ready channel carrying one command transaction.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface caldate_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [3:0]  load_month;
	logic [4:0]  load_day;
	logic [11:0] load_year;
	logic [15:0] advance_days;

	modport source (
		output valid, command, load_month, load_day, load_year, advance_days,
		input  ready
	);
	modport sink (
		input  valid, command, load_month, load_day, load_year, advance_days,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/caldate_out_if.sv
// caldate_out_if: valid/ready channel carrying one date/status result transaction.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface caldate_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;
	logic [11:0] cur_year;
	logic [2:0]  status;

	modport source (
		output valid, cur_month, cur_day, cur_year, status,
		input  ready
	);
	modport sink (
		input  valid, cur_month, cur_day, cur_year, status,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/caldate_ctrl.sv
// caldate_ctrl: sequencing state machine for the date counter.
// Depends on caldate_pkg; drives caldate_dp through dp_cmd_t / dp_sts_t.
`timescale 1ns / 1ps
`default_nettype none

module caldate_ctrl
	import caldate_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_command,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_STEP   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_command == CMD_LOAD) begin
						cmd.load = 1'b1;
						state_d  = S_FINISH;
					end else begin
						cmd.adv_start = 1'b1;
						state_d       = S_STEP;
					end
				end
			end
			S_STEP: begin
				if (sts.cnt_zero) begin
					state_d = S_FINISH;
				end else if (sts.at_top) begin
					cmd.ovf = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_wr = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/caldate_dp.sv
// caldate_dp: date registers, load checker, day stepper, day counter, output register.
// Depends on caldate_pkg; commanded by caldate_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module caldate_dp
	import caldate_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	input  wire item_t   item,
	input  wire logic    out_ready,
	output logic         out_valid,
	output result_t      result
);

	logic [3:0]            month_q;
	logic [4:0]            day_q;
	logic [11:0]           year_q;
	status_t               status_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  out_valid_q;
	result_t               result_q;

	// load check, month first, then year, then day
	logic    [4:0]  ld_dim;
	status_t        ld_status;
	always_comb begin
		ld_dim = days_in(item.load_month, item.load_year);
		if (item.load_month < 4'd1 || item.load_month > MONTH_LAST) begin
			ld_status = ST_BAD_MONTH;
		end else if (item.load_year < YEAR_MIN || item.load_year > YEAR_MAX) begin
			ld_status = ST_BAD_YEAR;
		end else if (item.load_day < 5'd1 || item.load_day > ld_dim) begin
			ld_status = ST_BAD_DAY;
		end else begin
			ld_status = ST_OK;
		end
	end

	// day stepping
	logic [4:0] cur_dim;
	logic       month_end;
	assign cur_dim   = days_in(month_q, year_q);
	assign month_end = (day_q >= cur_dim);

	// day count, low COUNT_BITS bits of the request
	logic [31:0]           adv_ext;
	logic [COUNT_BITS-1:0] adv_cnt;
	assign adv_ext = 32'(item.advance_days);
	assign adv_cnt = adv_ext[COUNT_BITS-1:0];

	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.at_top   = month_end && !(month_q < MONTH_LAST) && !(year_q < YEAR_TOP);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q <= 4'd1;
			day_q   <= 5'd1;
			year_q  <= YEAR_MIN;
		end else if (cmd.load) begin
			if (ld_status == ST_OK) begin
				month_q <= item.load_month;
				day_q   <= item.load_day;
				year_q  <= item.load_year;
			end
		end else if (cmd.step) begin
			if (!month_end) begin
				day_q <= day_q + 5'd1;
			end else if (month_q < MONTH_LAST) begin
				month_q <= month_q + 4'd1;
				day_q   <= 5'd1;
			end else begin
				year_q  <= year_q + 12'd1;
				month_q <= 4'd1;
				day_q   <= 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= ld_status;
		end else if (cmd.adv_start) begin
			status_q <= ST_OK;
		end else if (cmd.ovf) begin
			status_q <= ST_OVERFLOW;
		end
		if (cmd.adv_start) begin
			cnt_q <= adv_cnt;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - COUNT_BITS'(1);
		end
		if (cmd.out_wr) begin
			result_q.cur_month <= month_q;
			result_q.cur_day   <= day_q;
			result_q.cur_year  <= year_q;
			result_q.status    <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

// File: rtl/calendar_date_counter_top.sv
// calendar_date_counter_top: Gregorian date counter, controller plus datapath.
// Depends on caldate_pkg, caldate_in_if, caldate_out_if, caldate_ctrl, caldate_dp.
//
//  channel  | dir | transaction carries
//  ---------+-----+---------------------------------------------------------
//  in_ch    | in  | command, load_month, load_day, load_year, advance_days
//  out_ch   | out | cur_month, cur_day, cur_year, status
//
// Sequence: a load is checked and applied at accept, then its result is captured in S_FINISH;
//   an advance by N days steps N days in S_STEP, then is captured in S_FINISH,
//   one day stepped per cycle in the datapath stepper
//   (fewer if the date saturates at 31 Dec 4095 first). The next accept follows in S_IDLE.
// Reset: arst_n clears the date to 1 Jan 1900, the state machine and the output valid.
// Stalls: the result sits in an output register, so a new transaction is taken
//   while the previous result waits; a held result only stalls the capture step.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_counter_top
	import caldate_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input wire logic      clk,
	input wire logic      arst_n,
	caldate_in_if.sink    in_ch,
	caldate_out_if.source out_ch
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	item_t   item;
	result_t result;

	// pack incoming payload for the datapath
	assign item.command      = in_ch.command;
	assign item.load_month   = in_ch.load_month;
	assign item.load_day     = in_ch.load_day;
	assign item.load_year    = in_ch.load_year;
	assign item.advance_days = in_ch.advance_days;

	// sequencer: decides load vs. advance, runs the step loop, gates result capture
	caldate_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.in_ready   (in_ch.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// date state, checks, stepper, day counter and output register
	caldate_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.result    (result)
	);

	// unpack result onto the output channel
	assign out_ch.cur_month = result.cur_month;
	assign out_ch.cur_day   = result.cur_day;
	assign out_ch.cur_year  = result.cur_year;
	assign out_ch.status    = result.status;

endmodule

`default_nettype wire
